@@ rtl/cpu_opcode_control_decoder_top_defines.svh @@
// Assertion macros for the opcode control decoder.
// Used by the top level; expects clk and rst in scope.
`ifndef CPU_OPCODE_CONTROL_DECODER_TOP_DEFINES_SVH
`define CPU_OPCODE_CONTROL_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define OCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("opcode decoder check failed");

// next-cycle implication
`define OCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("opcode decoder check failed");

`endif

@@ rtl/ocd_pkg.sv @@
// Types and codes for the opcode control decoder.
// Shared by ocd_decode and cpu_opcode_control_decoder_top; no dependencies.
`default_nettype none

package ocd_pkg;

  typedef struct packed {
    logic [2:0] pfx_code;
    logic [7:0] opcode;
  } op_item_t;

  typedef struct packed {
    logic [5:0] exec_action;
    logic [3:0] seq_template;
    logic [3:0] flag_kind;
    logic [2:0] op_select;
    logic       cond_used;
    logic [2:0] cond_code;
    logic [2:0] pair_select;
    logic [2:0] dest_reg;
    logic [2:0] src_reg;
    logic [2:0] wz_action;
    logic [3:0] special_mask;
    logic [5:0] restart_addr;
  } ctl_word_t;

  localparam logic [2:0] PREFIX_NONE = 3'd0;
  localparam logic [2:0] HL_IDX      = 3'd6;

  localparam logic [5:0] ACT_NOP        = 6'd0;
  localparam logic [5:0] ACT_EX_AF      = 6'd1;
  localparam logic [5:0] ACT_DJNZ       = 6'd2;
  localparam logic [5:0] ACT_JR         = 6'd3;
  localparam logic [5:0] ACT_JR_CC      = 6'd4;
  localparam logic [5:0] ACT_LD_RP_NN   = 6'd5;
  localparam logic [5:0] ACT_ADD_HL_RP  = 6'd6;
  localparam logic [5:0] ACT_LD_RP_A    = 6'd7;
  localparam logic [5:0] ACT_LD_NN_HL   = 6'd8;
  localparam logic [5:0] ACT_LD_NN_A    = 6'd9;
  localparam logic [5:0] ACT_LD_A_RP    = 6'd10;
  localparam logic [5:0] ACT_LD_HL_NN   = 6'd11;
  localparam logic [5:0] ACT_LD_A_NN    = 6'd12;
  localparam logic [5:0] ACT_INC_RP     = 6'd13;
  localparam logic [5:0] ACT_DEC_RP     = 6'd14;
  localparam logic [5:0] ACT_INC_M      = 6'd15;
  localparam logic [5:0] ACT_INC_R      = 6'd16;
  localparam logic [5:0] ACT_DEC_M      = 6'd17;
  localparam logic [5:0] ACT_DEC_R      = 6'd18;
  localparam logic [5:0] ACT_LD_M_N     = 6'd19;
  localparam logic [5:0] ACT_LD_R_N     = 6'd20;
  localparam logic [5:0] ACT_ROT_A      = 6'd21;
  localparam logic [5:0] ACT_DAA        = 6'd22;
  localparam logic [5:0] ACT_CPL        = 6'd23;
  localparam logic [5:0] ACT_SCF        = 6'd24;
  localparam logic [5:0] ACT_CCF        = 6'd25;
  localparam logic [5:0] ACT_HALT       = 6'd26;
  localparam logic [5:0] ACT_LD_R_M     = 6'd27;
  localparam logic [5:0] ACT_ST_M_R     = 6'd28;
  localparam logic [5:0] ACT_LD_R_R     = 6'd29;
  localparam logic [5:0] ACT_ALU_M      = 6'd30;
  localparam logic [5:0] ACT_ALU_R      = 6'd31;
  localparam logic [5:0] ACT_RET_CC     = 6'd32;
  localparam logic [5:0] ACT_POP        = 6'd33;
  localparam logic [5:0] ACT_RET        = 6'd34;
  localparam logic [5:0] ACT_EXX        = 6'd35;
  localparam logic [5:0] ACT_JP_HL      = 6'd36;
  localparam logic [5:0] ACT_LD_SP_HL   = 6'd37;
  localparam logic [5:0] ACT_JP_CC      = 6'd38;
  localparam logic [5:0] ACT_JP         = 6'd39;
  localparam logic [5:0] ACT_PREFIX     = 6'd40;
  localparam logic [5:0] ACT_OUT_N_A    = 6'd41;
  localparam logic [5:0] ACT_IN_A_N     = 6'd42;
  localparam logic [5:0] ACT_EX_SP_HL   = 6'd43;
  localparam logic [5:0] ACT_EX_DE_HL   = 6'd44;
  localparam logic [5:0] ACT_DI         = 6'd45;
  localparam logic [5:0] ACT_EI         = 6'd46;
  localparam logic [5:0] ACT_CALL_CC    = 6'd47;
  localparam logic [5:0] ACT_PUSH       = 6'd48;
  localparam logic [5:0] ACT_CALL       = 6'd49;
  localparam logic [5:0] ACT_ALU_N      = 6'd50;
  localparam logic [5:0] ACT_RST        = 6'd51;
  localparam logic [5:0] ACT_ILLEGAL    = 6'd52;

  localparam logic [3:0] TPL_NONE  = 4'd0;
  localparam logic [3:0] TPL_JR    = 4'd1;
  localparam logic [3:0] TPL_IMM16 = 4'd2;
  localparam logic [3:0] TPL_MWR   = 4'd3;
  localparam logic [3:0] TPL_MRD   = 4'd4;
  localparam logic [3:0] TPL_RMW   = 4'd5;
  localparam logic [3:0] TPL_IMM8  = 4'd6;
  localparam logic [3:0] TPL_RET   = 4'd7;
  localparam logic [3:0] TPL_POP   = 4'd8;
  localparam logic [3:0] TPL_IO    = 4'd9;
  localparam logic [3:0] TPL_CALL  = 4'd10;
  localparam logic [3:0] TPL_PUSH  = 4'd11;

  localparam logic [3:0] FLG_NONE  = 4'd0;
  localparam logic [3:0] FLG_ADD8  = 4'd1;
  localparam logic [3:0] FLG_SUB8  = 4'd2;
  localparam logic [3:0] FLG_LOGIC = 4'd3;
  localparam logic [3:0] FLG_CP8   = 4'd4;
  localparam logic [3:0] FLG_ADD16 = 4'd5;
  localparam logic [3:0] FLG_INC8  = 4'd6;
  localparam logic [3:0] FLG_DEC8  = 4'd7;
  localparam logic [3:0] FLG_ROTA  = 4'd8;
  localparam logic [3:0] FLG_DAA   = 4'd9;
  localparam logic [3:0] FLG_CPL   = 4'd10;
  localparam logic [3:0] FLG_SCF   = 4'd11;
  localparam logic [3:0] FLG_CCF   = 4'd12;

  localparam logic [2:0] WZ_NONE  = 3'd0;
  localparam logic [2:0] WZ_ADDR1 = 3'd1;
  localparam logic [2:0] WZ_NN1   = 3'd2;
  localparam logic [2:0] WZ_DEST  = 3'd3;
  localparam logic [2:0] WZ_NN    = 3'd4;
  localparam logic [2:0] WZ_IO    = 3'd5;

  localparam logic [2:0] PAIR_SP = 3'd3;
  localparam logic [2:0] PAIR_AF = 3'd4;

  localparam logic [3:0] SPM_HALT   = 4'b0001;
  localparam logic [3:0] SPM_PREFIX = 4'b0010;
  localparam logic [3:0] SPM_DI     = 4'b0100;
  localparam logic [3:0] SPM_EI     = 4'b1000;

endpackage

`default_nettype wire

@@ rtl/ocd_decode.sv @@
// Combinational opcode decoder: one transaction in, one control word out.
// Depends on ocd_pkg.
`default_nettype none

module ocd_decode (
  input  wire ocd_pkg::op_item_t item,
  output ocd_pkg::ctl_word_t     word
);

  logic [1:0] x;
  logic [2:0] y;
  logic [2:0] z;
  logic [1:0] p;
  logic       q;
  logic [2:0] p_pair;
  logic [2:0] p_stack;
  logic [3:0] alu_flag;

  assign x       = item.opcode[7:6];
  assign y       = item.opcode[5:3];
  assign z       = item.opcode[2:0];
  assign p       = y[2:1];
  assign q       = y[0];
  assign p_pair  = {1'b0, p};
  assign p_stack = (p_pair == ocd_pkg::PAIR_SP) ? ocd_pkg::PAIR_AF : p_pair;

  always_comb begin
    case (y) inside
      3'd0, 3'd1:       alu_flag = ocd_pkg::FLG_ADD8;
      3'd2, 3'd3:       alu_flag = ocd_pkg::FLG_SUB8;
      3'd4, 3'd5, 3'd6: alu_flag = ocd_pkg::FLG_LOGIC;
      default:          alu_flag = ocd_pkg::FLG_CP8;
    endcase
  end

  always_comb begin
    word = '0;
    if (item.pfx_code != ocd_pkg::PREFIX_NONE) begin
      word.exec_action = ocd_pkg::ACT_ILLEGAL;
    end else begin
      unique case (x)
        2'd0: begin
          unique case (z)
            3'd0: begin
              unique case (y)
                3'd0: word.exec_action = ocd_pkg::ACT_NOP;
                3'd1: word.exec_action = ocd_pkg::ACT_EX_AF;
                3'd2: begin
                  word.exec_action  = ocd_pkg::ACT_DJNZ;
                  word.seq_template = ocd_pkg::TPL_JR;
                  word.cond_used    = 1'b1;
                end
                3'd3: begin
                  word.exec_action  = ocd_pkg::ACT_JR;
                  word.seq_template = ocd_pkg::TPL_JR;
                end
                default: begin
                  word.exec_action  = ocd_pkg::ACT_JR_CC;
                  word.seq_template = ocd_pkg::TPL_JR;
                  word.cond_used    = 1'b1;
                  word.cond_code    = {1'b0, y[1:0]};
                end
              endcase
            end
            3'd1: begin
              word.pair_select = p_pair;
              if (!q) begin
                word.exec_action  = ocd_pkg::ACT_LD_RP_NN;
                word.seq_template = ocd_pkg::TPL_IMM16;
              end else begin
                word.exec_action = ocd_pkg::ACT_ADD_HL_RP;
                word.flag_kind   = ocd_pkg::FLG_ADD16;
              end
            end
            3'd2: begin
              if (!p[1]) begin
                word.pair_select  = p_pair;
                word.exec_action  = q ? ocd_pkg::ACT_LD_A_RP : ocd_pkg::ACT_LD_RP_A;
                word.seq_template = q ? ocd_pkg::TPL_MRD : ocd_pkg::TPL_MWR;
                word.wz_action    = ocd_pkg::WZ_ADDR1;
              end else begin
                if (!p[0]) begin
                  word.exec_action = q ? ocd_pkg::ACT_LD_HL_NN : ocd_pkg::ACT_LD_NN_HL;
                end else begin
                  word.exec_action = q ? ocd_pkg::ACT_LD_A_NN : ocd_pkg::ACT_LD_NN_A;
                end
                word.seq_template = ocd_pkg::TPL_IMM16;
                word.wz_action    = ocd_pkg::WZ_NN1;
              end
            end
            3'd3: begin
              word.exec_action = q ? ocd_pkg::ACT_DEC_RP : ocd_pkg::ACT_INC_RP;
              word.pair_select = p_pair;
            end
            3'd4: begin
              word.dest_reg     = y;
              word.src_reg      = y;
              word.exec_action  = (y == ocd_pkg::HL_IDX) ? ocd_pkg::ACT_INC_M
                                                         : ocd_pkg::ACT_INC_R;
              word.flag_kind    = ocd_pkg::FLG_INC8;
              word.seq_template = (y == ocd_pkg::HL_IDX) ? ocd_pkg::TPL_RMW
                                                         : ocd_pkg::TPL_NONE;
            end
            3'd5: begin
              word.dest_reg     = y;
              word.src_reg      = y;
              word.exec_action  = (y == ocd_pkg::HL_IDX) ? ocd_pkg::ACT_DEC_M
                                                         : ocd_pkg::ACT_DEC_R;
              word.flag_kind    = ocd_pkg::FLG_DEC8;
              word.seq_template = (y == ocd_pkg::HL_IDX) ? ocd_pkg::TPL_RMW
                                                         : ocd_pkg::TPL_NONE;
            end
            3'd6: begin
              word.dest_reg = y;
              if (y == ocd_pkg::HL_IDX) begin
                word.exec_action  = ocd_pkg::ACT_LD_M_N;
                word.seq_template = ocd_pkg::TPL_MWR;
              end else begin
                word.exec_action  = ocd_pkg::ACT_LD_R_N;
                word.seq_template = ocd_pkg::TPL_IMM8;
              end
            end
            default: begin
              unique case (y)
                3'd4: begin
                  word.exec_action = ocd_pkg::ACT_DAA;
                  word.flag_kind   = ocd_pkg::FLG_DAA;
                end
                3'd5: begin
                  word.exec_action = ocd_pkg::ACT_CPL;
                  word.flag_kind   = ocd_pkg::FLG_CPL;
                end
                3'd6: begin
                  word.exec_action = ocd_pkg::ACT_SCF;
                  word.flag_kind   = ocd_pkg::FLG_SCF;
                end
                3'd7: begin
                  word.exec_action = ocd_pkg::ACT_CCF;
                  word.flag_kind   = ocd_pkg::FLG_CCF;
                end
                default: begin
                  word.exec_action = ocd_pkg::ACT_ROT_A;
                  word.flag_kind   = ocd_pkg::FLG_ROTA;
                  word.op_select   = y;
                end
              endcase
            end
          endcase
        end
        2'd1: begin
          if (y == ocd_pkg::HL_IDX && z == ocd_pkg::HL_IDX) begin
            word.exec_action  = ocd_pkg::ACT_HALT;
            word.special_mask = ocd_pkg::SPM_HALT;
          end else if (z == ocd_pkg::HL_IDX) begin
            word.exec_action  = ocd_pkg::ACT_LD_R_M;
            word.dest_reg     = y;
            word.seq_template = ocd_pkg::TPL_MRD;
          end else if (y == ocd_pkg::HL_IDX) begin
            word.exec_action  = ocd_pkg::ACT_ST_M_R;
            word.src_reg      = z;
            word.seq_template = ocd_pkg::TPL_MWR;
          end else begin
            word.exec_action = ocd_pkg::ACT_LD_R_R;
            word.dest_reg    = y;
            word.src_reg     = z;
          end
        end
        2'd2: begin
          word.op_select = y;
          word.flag_kind = alu_flag;
          if (z == ocd_pkg::HL_IDX) begin
            word.exec_action  = ocd_pkg::ACT_ALU_M;
            word.seq_template = ocd_pkg::TPL_MRD;
          end else begin
            word.exec_action = ocd_pkg::ACT_ALU_R;
            word.src_reg     = z;
          end
        end
        default: begin
          unique case (z)
            3'd0: begin
              word.exec_action  = ocd_pkg::ACT_RET_CC;
              word.seq_template = ocd_pkg::TPL_RET;
              word.cond_used    = 1'b1;
              word.cond_code    = y;
              word.wz_action    = ocd_pkg::WZ_DEST;
            end
            3'd1: begin
              if (!q) begin
                word.exec_action  = ocd_pkg::ACT_POP;
                word.seq_template = ocd_pkg::TPL_POP;
                word.pair_select  = p_stack;
              end else begin
                unique case (p)
                  2'd0: begin
                    word.exec_action  = ocd_pkg::ACT_RET;
                    word.seq_template = ocd_pkg::TPL_RET;
                    word.wz_action    = ocd_pkg::WZ_DEST;
                  end
                  2'd1: word.exec_action = ocd_pkg::ACT_EXX;
                  2'd2: word.exec_action = ocd_pkg::ACT_JP_HL;
                  default: word.exec_action = ocd_pkg::ACT_LD_SP_HL;
                endcase
              end
            end
            3'd2: begin
              word.exec_action  = ocd_pkg::ACT_JP_CC;
              word.seq_template = ocd_pkg::TPL_IMM16;
              word.cond_used    = 1'b1;
              word.cond_code    = y;
              word.wz_action    = ocd_pkg::WZ_NN;
            end
            3'd3: begin
              unique case (y)
                3'd0: begin
                  word.exec_action  = ocd_pkg::ACT_JP;
                  word.seq_template = ocd_pkg::TPL_IMM16;
                  word.wz_action    = ocd_pkg::WZ_NN;
                end
                3'd1: begin
                  word.exec_action  = ocd_pkg::ACT_PREFIX;
                  word.special_mask = ocd_pkg::SPM_PREFIX;
                end
                3'd2: begin
                  word.exec_action  = ocd_pkg::ACT_OUT_N_A;
                  word.seq_template = ocd_pkg::TPL_IO;
                  word.wz_action    = ocd_pkg::WZ_IO;
                end
                3'd3: begin
                  word.exec_action  = ocd_pkg::ACT_IN_A_N;
                  word.seq_template = ocd_pkg::TPL_IO;
                  word.wz_action    = ocd_pkg::WZ_IO;
                end
                3'd4: begin
                  word.exec_action  = ocd_pkg::ACT_EX_SP_HL;
                  word.seq_template = ocd_pkg::TPL_POP;
                  word.wz_action    = ocd_pkg::WZ_DEST;
                end
                3'd5: word.exec_action = ocd_pkg::ACT_EX_DE_HL;
                3'd6: begin
                  word.exec_action  = ocd_pkg::ACT_DI;
                  word.special_mask = ocd_pkg::SPM_DI;
                end
                default: begin
                  word.exec_action  = ocd_pkg::ACT_EI;
                  word.special_mask = ocd_pkg::SPM_EI;
                end
              endcase
            end
            3'd4: begin
              word.exec_action  = ocd_pkg::ACT_CALL_CC;
              word.seq_template = ocd_pkg::TPL_CALL;
              word.cond_used    = 1'b1;
              word.cond_code    = y;
              word.wz_action    = ocd_pkg::WZ_NN;
            end
            3'd5: begin
              if (!q) begin
                word.exec_action  = ocd_pkg::ACT_PUSH;
                word.seq_template = ocd_pkg::TPL_PUSH;
                word.pair_select  = p_stack;
              end else if (p == 2'd0) begin
                word.exec_action  = ocd_pkg::ACT_CALL;
                word.seq_template = ocd_pkg::TPL_CALL;
                word.wz_action    = ocd_pkg::WZ_NN;
              end else begin
                word.exec_action  = ocd_pkg::ACT_PREFIX;
                word.special_mask = ocd_pkg::SPM_PREFIX;
              end
            end
            3'd6: begin
              word.exec_action  = ocd_pkg::ACT_ALU_N;
              word.op_select    = y;
              word.flag_kind    = alu_flag;
              word.seq_template = ocd_pkg::TPL_IMM8;
            end
            default: begin
              word.exec_action  = ocd_pkg::ACT_RST;
              word.restart_addr = {y, 3'b000};
              word.seq_template = ocd_pkg::TPL_CALL;
            end
          endcase
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/cpu_opcode_control_decoder_top.sv @@
// A transaction accepted into s1_item is decoded, and the result is registered into ctl_word when s2_load allows.
// Throughput: one opcode per cycle; input register, decode logic and result register
// form a two-stage pipeline that stalls only when both stages hold and the output stalls.
// Reset: synchronous rst empties both stages; payload registers are not cleared.
// Depends on ocd_pkg, ocd_decode and cpu_opcode_control_decoder_top_defines.svh.
`default_nettype none
`include "cpu_opcode_control_decoder_top_defines.svh"

module cpu_opcode_control_decoder_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               op_valid,
  output      logic               op_stall,
  input  wire ocd_pkg::op_item_t  op_item,
  output      logic               ctl_valid,
  input  wire logic               ctl_stall,
  output ocd_pkg::ctl_word_t      ctl_word
);

  logic               s1_valid;
  ocd_pkg::op_item_t  s1_item;
  ocd_pkg::ctl_word_t dec_word;
  logic               s1_load;
  logic               s2_load;

  assign s2_load  = s1_valid && (!ctl_valid || !ctl_stall);
  assign op_stall = s1_valid && ctl_valid && ctl_stall;
  assign s1_load  = op_valid && !op_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item <= op_item;
    end
  end

  ocd_decode u_decode (
    .item (s1_item),
    .word (dec_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_valid <= 1'b0;
    end else if (s2_load) begin
      ctl_valid <= 1'b1;
    end else if (!ctl_stall) begin
      ctl_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      ctl_word <= dec_word;
    end
  end

  `OCD_ASSERT_NEXT(a_hold_stage1, s1_valid && ctl_valid && ctl_stall,
                   s1_valid && $stable(s1_item))
  `OCD_ASSERT_NEXT(a_fill_stage1, op_valid && !s1_valid, s1_valid)
  `OCD_ASSERT_NOW(a_special_onehot, ctl_valid, $onehot0(ctl_word.special_mask))
  `OCD_ASSERT_NOW(a_illegal_clean,
                  ctl_valid && ctl_word.exec_action == ocd_pkg::ACT_ILLEGAL,
                  ctl_word.seq_template == ocd_pkg::TPL_NONE &&
                  ctl_word.special_mask == 4'b0000 && !ctl_word.cond_used)

endmodule

`default_nettype wire
